// ===== design/ccrs_pkg.sv =====
// ---------------------------------------------------------------------------
// ccrs_pkg: shared types and constants for the camera channel sequencer
// Payload structs, operation and message codes, and the decoded plan of one
// event handed from the front end to the back end.
// ---------------------------------------------------------------------------
package ccrs_pkg;

  localparam int unsigned MediaTableSize = 64;
  localparam int unsigned CreditLimit    = 8;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [3:0] {
    OP_OPEN_OK   = 4'd0,
    OP_SUCCESS   = 4'd1,
    OP_ERROR     = 4'd2,
    OP_STREAM    = 4'd3,
    OP_MEDIA     = 4'd4,
    OP_SAMPLE    = 4'd5,
    OP_SAMPLE_ER = 4'd6,
    OP_START     = 4'd7,
    OP_STOP      = 4'd8,
    OP_RESET     = 4'd9
  } op_e;

  localparam logic [7:0] MsgActivate   = 8'h07;
  localparam logic [7:0] MsgDeactivate = 8'h08;
  localparam logic [7:0] MsgStreams    = 8'h09;
  localparam logic [7:0] MsgMedia      = 8'h0B;
  localparam logic [7:0] MsgStart      = 8'h0F;
  localparam logic [7:0] MsgStop       = 8'h10;
  localparam logic [7:0] MsgSample     = 8'h11;

  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvReady    = 3'd1;
  localparam logic [2:0] EvStarted  = 3'd2;
  localparam logic [2:0] EvStopped  = 3'd3;
  localparam logic [2:0] EvSample   = 3'd4;
  localparam logic [2:0] EvRejected = 3'd6;

  localparam logic [7:0] CaptureCategory = 8'h01;
  localparam logic [15:0] ColourSource   = 16'h0001;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] fault_code;
    logic [15:0] src_kind_bits;
    logic [7:0]  stream_category;
    logic        list_has_entry;
    logic        list_last;
    logic [15:0] media_type_count;
    logic [7:0]  sample_stream_index;
    logic [5:0]  media_type_select;
  } in_item_t;

  typedef struct packed {
    logic        request_valid;
    logic [7:0]  request_code;
    logic [7:0]  request_arg;
    logic [2:0]  event_code;
    logic [31:0] event_value;
    logic        last;
  } out_item_t;

  // Plan of one event: up to two notifications, a burst of samples, then a request.
  typedef struct packed {
    logic        ev0_vld;    // leading notification
    logic [2:0]  ev0_code;
    logic [31:0] ev0_val;
    logic        ev1_vld;    // second notification (device ready)
    logic [2:0]  ev1_code;
    logic [31:0] ev1_val;
    logic [3:0]  samples;    // sample requests after the notifications
    logic [7:0]  sample_arg;
    logic        req_vld;    // trailing request
    logic [7:0]  req_code;
    logic [7:0]  req_arg;
  } plan_t;

endpackage

// ===== design/ccrs_front.sv =====
// ---------------------------------------------------------------------------
// ccrs_front: event decode and device state
// Applies one event to the device state and writes the list of results it
// causes as a plan into the queue.
// ---------------------------------------------------------------------------
module ccrs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ccrs_pkg::in_item_t in_data_i,
  input  logic [3:0]         credits_cfg_i,
  output logic               plan_valid_o,
  input  logic               plan_ready_i,
  output ccrs_pkg::plan_t    plan_o
);

  localparam logic [2:0] StUnused = 3'd0, StIdle = 3'd2, StActive = 3'd3,
                         StStream = 3'd4, StClosing = 3'd5, StFailed = 3'd6;
  localparam logic [2:0] PrNone = 3'd0, PrActivate = 3'd1, PrDeactivate = 3'd2,
                         PrStreams = 3'd3, PrMedia = 3'd4, PrStart = 3'd5,
                         PrStop = 3'd6;

  logic [2:0] st_q, st_d, pr_q, pr_d, fl_q, fl_d;
  logic [7:0] cap_q, cap_d, cnt_q, cnt_d;
  logic [6:0] held_q, held_d;
  logic       want_q, want_d;
  logic [5:0] wm_q, wm_d, rm_q, rm_d;
  logic [3:0] cr_q, cr_d;
  ccrs_pkg::plan_t pl;
  logic       emit_any;
  logic [3:0] limit;
  logic [6:0] clamp;
  logic       do_adv, do_samp;
  logic [3:0] cr_a;

  assign in_ready_o   = plan_ready_i;
  assign plan_valid_o = in_valid_i && emit_any;
  assign plan_o       = pl;
  assign limit = (credits_cfg_i > 4'(ccrs_pkg::CreditLimit)) ?
                 4'(ccrs_pkg::CreditLimit) : credits_cfg_i;
  assign clamp = (in_data_i.media_type_count > 16'(ccrs_pkg::MediaTableSize)) ?
                 7'(ccrs_pkg::MediaTableSize) : in_data_i.media_type_count[6:0];

  // Decode the event into next state and a plan of results
  always_comb begin
    logic [31:0] ecode;
    st_d = st_q; pr_d = pr_q; fl_d = fl_q; cap_d = cap_q; cnt_d = cnt_q;
    held_d = held_q; want_d = want_q; wm_d = wm_q; rm_d = rm_q; cr_d = cr_q;
    pl = '0;
    do_adv = 1'b0; do_samp = 1'b0;
    ecode = (in_data_i.fault_code != 32'd0) ? in_data_i.fault_code : 32'd1;
    unique case (in_data_i.operation)
      ccrs_pkg::OP_OPEN_OK: if (st_q == StUnused) begin
        st_d = StIdle; do_adv = 1'b1;
      end
      ccrs_pkg::OP_SUCCESS: if (st_q != StUnused) begin
        pr_d = PrNone; do_adv = 1'b1;
        priority case (pr_q)
          PrActivate:   st_d = StActive;
          PrDeactivate: st_d = StIdle;
          PrStart: begin
            st_d = StStream; rm_d = wm_q; cr_d = '0;
            pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvStarted;
            pl.ev0_val = {26'd0, wm_q};
            do_samp = want_q;
          end
          PrStop: begin
            st_d = StActive; cr_d = '0;
            pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvStopped;
          end
          default: ;
        endcase
      end
      ccrs_pkg::OP_ERROR: if (st_q != StUnused) begin
        pr_d = PrNone;
        if (!fl_q[0]) st_d = StFailed;
        else begin
          do_adv = 1'b1;
          priority case (pr_q)
            PrActivate, PrStart: begin
              want_d = 1'b0; cr_d = '0;
              pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvStopped; pl.ev0_val = ecode;
            end
            PrStop: begin
              st_d = StActive; cr_d = '0;
              pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvStopped;
            end
            PrDeactivate: st_d = StIdle;
            default: ;
          endcase
        end
      end
      ccrs_pkg::OP_STREAM: if (st_q != StUnused) begin
        if (in_data_i.list_has_entry) begin
          if (!fl_q[1] && in_data_i.src_kind_bits[0] &&
              in_data_i.stream_category == ccrs_pkg::CaptureCategory) begin
            fl_d[1] = 1'b1; cap_d = cnt_q;
          end
          cnt_d = cnt_q + 8'd1;
        end
        if (in_data_i.list_last) begin
          pr_d = PrNone; cnt_d = '0;
          if (!fl_d[1]) st_d = StFailed;
          else do_adv = 1'b1;
        end
      end
      ccrs_pkg::OP_MEDIA: if (st_q != StUnused) begin
        pr_d = PrNone; held_d = clamp;
        if (clamp == 7'd0) st_d = StFailed;
        else begin
          fl_d[2] = 1'b1; do_adv = 1'b1;
        end
      end
      ccrs_pkg::OP_SAMPLE: if (st_q != StUnused) begin
        if (cr_q != 4'd0) cr_d = cr_q - 4'd1;
        if (st_q == StStream && in_data_i.sample_stream_index == cap_q) begin
          pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvSample;
          do_samp = want_q && (rm_q == wm_q);
        end
      end
      ccrs_pkg::OP_SAMPLE_ER: if (st_q != StUnused) begin
        if (cr_q != 4'd0) cr_d = cr_q - 4'd1;
        if (st_q == StStream) begin
          want_d = 1'b0; do_adv = 1'b1;
        end
      end
      ccrs_pkg::OP_START: begin
        if (!fl_q[0] || st_q == StFailed || st_q == StClosing ||
            {1'b0, in_data_i.media_type_select} >= held_q) begin
          pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvRejected;
          pl.ev0_val = {26'd0, in_data_i.media_type_select};
        end else begin
          want_d = 1'b1; wm_d = in_data_i.media_type_select; do_adv = 1'b1;
        end
      end
      ccrs_pkg::OP_STOP: begin
        if (st_q == StUnused) begin
          pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvRejected;
        end else begin
          want_d = 1'b0; do_adv = 1'b1;
        end
      end
      ccrs_pkg::OP_RESET: begin
        if (st_q == StStream) begin
          pl.ev0_vld = 1'b1; pl.ev0_code = ccrs_pkg::EvStopped;
        end
        st_d = StUnused; pr_d = PrNone; fl_d = '0; cap_d = '0; cnt_d = '0;
        held_d = '0; want_d = 1'b0; wm_d = '0; rm_d = '0; cr_d = '0;
      end
      default: ;
    endcase

    // Issue the sample burst up to the credit limit
    cr_a = cr_d;
    if (do_samp && cr_d < limit) begin
      pl.samples = limit - cr_d; pl.sample_arg = cap_d; cr_a = limit;
    end
    cr_d = cr_a;

    // Pick the next request once nothing is outstanding
    if (do_adv && pr_d == PrNone) begin
      if (!fl_d[0] && !(fl_d[1] && fl_d[2])) begin
        if (st_d == StIdle) begin
          pr_d = PrActivate; pl.req_vld = 1'b1; pl.req_code = ccrs_pkg::MsgActivate;
        end else if (st_d == StActive) begin
          pl.req_vld = 1'b1;
          if (!fl_d[1]) begin
            pr_d = PrStreams; pl.req_code = ccrs_pkg::MsgStreams;
          end else begin
            pr_d = PrMedia; pl.req_code = ccrs_pkg::MsgMedia; pl.req_arg = cap_d;
          end
        end
      end else begin
        if (!fl_d[0]) begin
          fl_d[0] = 1'b1;
          pl.ev1_vld = 1'b1; pl.ev1_code = ccrs_pkg::EvReady;
          pl.ev1_val = {25'd0, held_d};
        end
        if (want_d) begin
          if (st_d == StIdle) begin
            pr_d = PrActivate; pl.req_vld = 1'b1; pl.req_code = ccrs_pkg::MsgActivate;
          end else if (st_d == StActive) begin
            pr_d = PrStart; pl.req_vld = 1'b1; pl.req_code = ccrs_pkg::MsgStart;
            pl.req_arg = {2'b00, wm_d};
          end else if (st_d == StStream && rm_d != wm_d) begin
            pr_d = PrStop; pl.req_vld = 1'b1; pl.req_code = ccrs_pkg::MsgStop;
          end
        end else begin
          if (st_d == StStream) begin
            pr_d = PrStop; pl.req_vld = 1'b1; pl.req_code = ccrs_pkg::MsgStop;
          end else if (st_d == StActive) begin
            pr_d = PrDeactivate; pl.req_vld = 1'b1;
            pl.req_code = ccrs_pkg::MsgDeactivate;
          end
        end
      end
    end
    emit_any = pl.ev0_vld || pl.ev1_vld || pl.req_vld || (pl.samples != 4'd0);
  end

  // Commit state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StUnused; pr_q <= PrNone; fl_q <= '0; cap_q <= '0; cnt_q <= '0;
      held_q <= '0; want_q <= 1'b0; wm_q <= '0; rm_q <= '0; cr_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      st_q <= st_d; pr_q <= pr_d; fl_q <= fl_d; cap_q <= cap_d; cnt_q <= cnt_d;
      held_q <= held_d; want_q <= want_d; wm_q <= wm_d; rm_q <= rm_d; cr_q <= cr_d;
    end
  end

endmodule

// ===== design/ccrs_queue.sv =====
// ---------------------------------------------------------------------------
// ccrs_queue: plan queue
// Short FIFO between decode and result sequencing.
// ---------------------------------------------------------------------------
module ccrs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  ccrs_pkg::plan_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output ccrs_pkg::plan_t rd_data_o
);

  localparam int unsigned Aw = $clog2(ccrs_pkg::QueueDepth);

  ccrs_pkg::plan_t mem_q [ccrs_pkg::QueueDepth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   n_q;
  logic          wr, rd;

  assign wr_ready_o = n_q != (Aw+1)'(ccrs_pkg::QueueDepth);
  assign rd_valid_o = n_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; n_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(ccrs_pkg::QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(ccrs_pkg::QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      n_q <= n_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

endmodule

// ===== design/ccrs_back.sv =====
// ---------------------------------------------------------------------------
// ccrs_back: result sequencer
// Walks one plan into a registered output, one beat per cycle unless stalled.
// ---------------------------------------------------------------------------
module ccrs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                plan_valid_i,
  output logic                plan_ready_o,
  input  ccrs_pkg::plan_t     plan_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccrs_pkg::out_item_t out_data_o
);

  localparam logic [1:0] PhEv0 = 2'd0, PhEv1 = 2'd1, PhSmp = 2'd2, PhReq = 2'd3;

  logic [1:0]  ph_q, ph_d;
  logic [3:0]  sn_q, sn_d;
  logic        ov_q;
  ccrs_pkg::out_item_t od_q, cur;
  logic        have, done, free;
  logic        r_e0, r_e1, r_sm, r_rq;

  assign free = !ov_q || out_ready_i;
  assign r_e0 = plan_i.ev0_vld && ph_q == PhEv0;
  assign r_e1 = plan_i.ev1_vld && ph_q <= PhEv1;
  assign r_sm = (plan_i.samples > sn_q) && ph_q <= PhSmp;
  assign r_rq = plan_i.req_vld;

  // Select the current result and the phase after it
  always_comb begin
    cur = '0; ph_d = ph_q; sn_d = sn_q; have = plan_valid_i; done = 1'b0;
    if (r_e0) begin
      cur.event_code = plan_i.ev0_code; cur.event_value = plan_i.ev0_val;
      ph_d = PhEv1;
      cur.last = !(plan_i.ev1_vld || plan_i.samples != 4'd0 || r_rq);
    end else if (r_e1) begin
      cur.event_code = plan_i.ev1_code; cur.event_value = plan_i.ev1_val;
      ph_d = PhSmp;
      cur.last = !(plan_i.samples != 4'd0 || r_rq);
    end else if (r_sm) begin
      cur.request_valid = 1'b1; cur.request_code = ccrs_pkg::MsgSample;
      cur.request_arg = plan_i.sample_arg;
      sn_d = sn_q + 4'd1; ph_d = PhSmp;
      cur.last = (sn_d == plan_i.samples) && !r_rq;
    end else begin
      cur.request_valid = 1'b1; cur.request_code = plan_i.req_code;
      cur.request_arg = plan_i.req_arg; ph_d = PhReq; cur.last = 1'b1;
    end
    if (cur.last) begin
      done = 1'b1; ph_d = PhEv0; sn_d = '0;
    end
  end

  assign plan_ready_o = have && free && done;
  assign out_valid_o  = ov_q;
  assign out_data_o   = od_q;

  // Hold the output register until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; ph_q <= PhEv0; sn_q <= '0;
    end else if (free) begin
      ov_q <= have;
      if (have) begin
        ph_q <= ph_d; sn_q <= sn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free && have) od_q <= cur;
  end

endmodule

// ===== design/camera_channel_request_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// camera_channel_request_sequencer_core: camera channel control sequencer
// Decodes device events, tracks state and emits requests and notifications.
//
//   channel  | direction | handshake
//   in       | input     | in_valid_i / in_ready_o, in_data_i
//   out      | output    | out_valid_o / out_ready_i, out_data_o
//   cfg      | APB       | psel/penable/pwrite, pready always high
//
// An event is decoded and its plan queued; the back end emits one result beat per
// cycle while the output is not stalled, and new events decode while the queue
// has room. Events that cause no result queue no plan. Reset clears the control
// state; the credit register resets to 3. A stalled output backs up the queue.
// ---------------------------------------------------------------------------
module camera_channel_request_sequencer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccrs_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [3:0] cred_q;
  logic       pv, pr, qv, qr;
  ccrs_pkg::plan_t pw, pq;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, cred_q} : 32'd0;

  // Write the credit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cred_q <= 4'd3;
    else if (psel && penable && pwrite && paddr == 2'd0) cred_q <= pwdata[3:0];
  end

  ccrs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .credits_cfg_i(cred_q), .plan_valid_o(pv), .plan_ready_i(pr), .plan_o(pw)
  );

  ccrs_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(pv), .wr_ready_o(pr), .wr_data_i(pw),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(pq)
  );

  ccrs_back u_back (
    .clk_i, .rst_ni, .plan_valid_i(qv), .plan_ready_o(qr), .plan_i(pq),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
